// File: hdl/spt_pkg.sv
package spt_pkg;

   localparam int OP_W         = 2;
   localparam int ADDR_W       = 48;
   localparam int BYTE_COUNT_W = 32;
   localparam int FLAGS_W      = 8;
   localparam int OWNER_W      = 32;
   localparam int FRAME_W      = 36;
   localparam int COUNT_W      = 9;

   localparam int ADDR_LSB   = 0;
   localparam int BCOUNT_LSB = ADDR_LSB + ADDR_W;
   localparam int FLAGS_LSB  = BCOUNT_LSB + BYTE_COUNT_W;
   localparam int OWNER_LSB  = FLAGS_LSB + FLAGS_W;
   localparam int QFRAME_LSB = OWNER_LSB + OWNER_W;
   localparam int REQ_BITS   = QFRAME_LSB + FRAME_W;

   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_BITS   = 1 + 3 * COUNT_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_TAG         = 2'd0,
      OP_UNTAG       = 2'd1,
      OP_QUERY_FRAME = 2'd2,
      OP_QUERY_OWNER = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_TAG_RUN,
      ST_WALK_READ,
      ST_WALK_CMP,
      ST_UNTAG_MOVE,
      ST_DONE
   } state_type;

endpackage

// File: hdl/spt_ram.sv
module spt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/sensitive_page_tag_table.sv
// A tag transaction appends one entry per frame of its range until the range ends or the table fills.
// An untag or query transaction examines entries one at a time through the single RAM
// read port, and an untag moves the last entry into each slot it frees; a query stops at a
// match, and an untag that names address zero skips the walk.
// One transaction is processed at a time; the next is accepted while the result waits.
// Synchronous reset empties the table by clearing the entry count; the RAM is not swept.
module sensitive_page_tag_table #(
   parameter int TABLE_DEPTH  = 256,
   parameter int PAGE_BITS    = 12,
   parameter int ADDRESS_BITS = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // address, byte_count, sensitivity_flags, owner_id, frame, zero padding
   input  logic [spt_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  logic [spt_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // found, added_count, removed_count, entry_count, table_full, zero padding
   output logic [spt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import spt_pkg::*;

   localparam int FW   = ADDRESS_BITS - PAGE_BITS;
   localparam int EW   = FW + FLAGS_W + OWNER_W;
   localparam int CW   = FW > FRAME_W ? FW : FRAME_W;
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int IW   = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
   localparam int SUMW = ADDR_W + 2;
   localparam int FRW  = SUMW - PAGE_BITS;

   localparam logic [ADDR_W-1:0] ADDR_MASK     = (ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1);
   localparam logic [SUMW-1:0]   PAGE_LESS_ONE = (SUMW'(1) << PAGE_BITS) - SUMW'(1);
   localparam logic [CNTW-1:0]   DEPTH_CNT     = CNTW'(TABLE_DEPTH);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [BYTE_COUNT_W-1:0] bcount_ff, bcount_in;
   logic [FLAGS_W-1:0]      flags_ff, flags_in;
   logic [OWNER_W-1:0]      owner_ff, owner_in;
   logic [FRAME_W-1:0]      qframe_ff, qframe_in;
   logic [FRW-1:0]          f_ff, f_in;
   logic [FRW-1:0]          end_ff, end_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic [CNTW-1:0]         idx_ff, idx_in;
   logic [CNTW-1:0]         added_ff, added_in;
   logic [CNTW-1:0]         removed_ff, removed_in;
   logic                    found_ff, found_in;
   logic                    full_ff, full_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   logic [SUMW-1:0]    sum_w;
   logic [FRW-1:0]     first_w;
   logic [FW-1:0]      key_w;
   logic [FW-1:0]      rd_frame;
   logic [OWNER_W-1:0] rd_owner;
   logic [CNTW-1:0]    cnt_less_one;
   logic               hit;
   logic               in_range;
   logic               has_room;
   logic               more;
   logic               out_free;

   spt_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sum_w        = {2'b00, addr_ff} + SUMW'(bcount_ff) + PAGE_LESS_ONE;
   assign first_w      = FRW'({2'b00, addr_ff} >> PAGE_BITS);
   assign key_w        = FW'(addr_ff >> PAGE_BITS);
   assign rd_frame     = rd_data[FW-1:0];
   assign rd_owner     = rd_data[EW-1:FW+FLAGS_W];
   assign cnt_less_one = cnt_ff - CNTW'(1);
   assign in_range     = f_ff < end_ff;
   assign has_room     = cnt_ff < DEPTH_CNT;
   assign more         = idx_ff < cnt_ff;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (op_ff)
         OP_UNTAG:       hit = rd_frame == key_w;
         OP_QUERY_FRAME: hit = CW'(rd_frame) == CW'(qframe_ff);
         OP_QUERY_OWNER: hit = rd_owner == owner_ff;
         default:        hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (op_ff == OP_TAG) begin
               state_in = ST_TAG_RUN;
            end else if (op_ff == OP_UNTAG && addr_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK_READ;
            end
         end
         ST_TAG_RUN: begin
            if (!(in_range && has_room)) begin
               state_in = ST_DONE;
            end
         end
         ST_WALK_READ: begin
            state_in = more ? ST_WALK_CMP : ST_DONE;
         end
         ST_WALK_CMP: begin
            if (!hit) begin
               state_in = ST_WALK_READ;
            end else if (op_ff == OP_UNTAG) begin
               state_in = ST_UNTAG_MOVE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UNTAG_MOVE: begin
            state_in = ST_WALK_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      op_in        = op_ff;
      addr_in      = addr_ff;
      bcount_in    = bcount_ff;
      flags_in     = flags_ff;
      owner_in     = owner_ff;
      qframe_in    = qframe_ff;
      f_in         = f_ff;
      end_in       = end_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      added_in     = added_ff;
      removed_in   = removed_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_data      = rd_data;
      rd_addr      = idx_ff[IW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in      = op_type'(req_tuser[OP_W-1:0]);
               addr_in    = req_tdata[ADDR_LSB +: ADDR_W] & ADDR_MASK;
               bcount_in  = req_tdata[BCOUNT_LSB +: BYTE_COUNT_W];
               flags_in   = req_tdata[FLAGS_LSB +: FLAGS_W];
               owner_in   = req_tdata[OWNER_LSB +: OWNER_W];
               qframe_in  = req_tdata[QFRAME_LSB +: FRAME_W];
               added_in   = '0;
               removed_in = '0;
               found_in   = 1'b0;
               full_in    = 1'b0;
            end
         end
         ST_SETUP: begin
            f_in   = first_w;
            end_in = sum_w[SUMW-1:PAGE_BITS];
            idx_in = '0;
         end
         ST_TAG_RUN: begin
            if (in_range && has_room) begin
               wr_en    = 1'b1;
               wr_addr  = cnt_ff[IW-1:0];
               wr_data  = {owner_ff, flags_ff, FW'(f_ff)};
               cnt_in   = cnt_ff + CNTW'(1);
               added_in = added_ff + CNTW'(1);
               f_in     = f_ff + FRW'(1);
            end else if (in_range) begin
               full_in = 1'b1;
            end
         end
         ST_WALK_READ: begin
            rd_addr = idx_ff[IW-1:0];
         end
         ST_WALK_CMP: begin
            if (!hit) begin
               idx_in = idx_ff + CNTW'(1);
            end else if (op_ff == OP_UNTAG) begin
               rd_addr    = cnt_less_one[IW-1:0];
               cnt_in     = cnt_less_one;
               removed_in = removed_ff + CNTW'(1);
            end else begin
               found_in = 1'b1;
            end
         end
         ST_UNTAG_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = rd_data;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({full_ff, COUNT_W'(cnt_ff), COUNT_W'(removed_ff),
                                           COUNT_W'(added_ff), found_ff});
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      bcount_ff   <= bcount_in;
      flags_ff    <= flags_in;
      owner_ff    <= owner_in;
      qframe_ff   <= qframe_in;
      f_ff        <= f_in;
      end_ff      <= end_in;
      idx_ff      <= idx_in;
      added_ff    <= added_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_CNT)
      else $error("entry count exceeds the table depth");

   a_tag_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAG_RUN && in_range && has_room) |=> cnt_ff == $past(cnt_ff) + CNTW'(1))
      else $error("tag append did not advance the entry count");

   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UNTAG_MOVE) |-> (wr_en && idx_ff <= cnt_ff))
      else $error("untag move writes beyond the valid entries");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result was not loaded into the output register");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE && !wr_en))
      else $error("request accepted while a transaction is in progress");

endmodule
